[hdl/beacon_offset_median_sync_core_defines.svh]
// assertion macros for the beacon offset median sync core
`ifndef BEACON_OFFSET_MEDIAN_SYNC_CORE_DEFINES_SVH
`define BEACON_OFFSET_MEDIAN_SYNC_CORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define BMOS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BMOS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BMOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bmos_pkg.sv]
// shared types and constants for the beacon offset median sync core
`default_nettype none

package bmos_pkg;

    localparam int TIME_W      = 64;
    localparam int OP_W        = 2;
    localparam int STALE_W     = 20;
    localparam int LIMIT_W     = 30;
    localparam int US_PER_MS   = 1000;
    localparam int COUNT_OUT_W = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_BEACON = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic               REG_STALE_LIMIT = 1'b0;
    localparam logic [STALE_W-1:0] STALE_RESET     = 20'd2000;

    typedef logic [TIME_W-1:0] stamp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_PICK,
        S_MEAN,
        S_FIX,
        S_STALE,
        S_RES
    } seq_state_t;

    typedef struct packed {
        logic   del;
        logic   ins;
        stamp_t new_val;
    } cell_cmd_t;

endpackage

`default_nettype wire

[hdl/bmos_item_if.sv]
// item channel into the core: op code and timestamps
`default_nettype none

interface bmos_item_if import bmos_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    stamp_t          local_time_us;
    stamp_t          master_time_us;

    modport source (output valid, output op, output local_time_us, output master_time_us,
                    input ready);
    modport sink   (input valid, input op, input local_time_us, input master_time_us,
                    output ready);

endinterface

`default_nettype wire

[hdl/bmos_result_if.sv]
// result channel out of the core: offset, master time and status
`default_nettype none

interface bmos_result_if import bmos_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [TIME_W-1:0] clock_offset;
    stamp_t                   master_estimate;
    logic                     sync_valid;
    logic [COUNT_OUT_W-1:0]   sample_count;

    modport source (output valid, output clock_offset, output master_estimate,
                    output sync_valid, output sample_count, input ready);
    modport sink   (input valid, input clock_offset, input master_estimate,
                    input sync_valid, input sample_count, output ready);

endinterface

`default_nettype wire

[hdl/bmos_cell.sv]
// one cell of the sorted offset chain: value, ring slot tag and neighbor moves
`default_nettype none

module bmos_cell import bmos_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int IDX   = 0,
    localparam int TAG_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [TAG_W-1:0] new_tag,
    input  logic [TAG_W-1:0] del_tag,
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] lo_idx,
    input  logic [CNT_W-1:0] hi_idx,
    input  stamp_t           prev_val,
    input  logic [TAG_W-1:0] prev_tag,
    input  logic             prev_gt,
    input  stamp_t           next_val,
    input  logic [TAG_W-1:0] next_tag,
    input  logic             del_in,
    input  stamp_t           lo_in,
    input  stamp_t           hi_in,
    output stamp_t           val,
    output logic [TAG_W-1:0] tag,
    output logic             gt,
    output logic             del_out,
    output stamp_t           lo_out,
    output stamp_t           hi_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    stamp_t           val_reg;
    stamp_t           val_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic             live;

    assign live    = MY_IDX < count;
    assign del_out = del_in || (live && (tag_reg == del_tag));
    assign gt      = !live || ($signed(val_reg) > $signed(cmd.new_val));
    assign val     = val_reg;
    assign tag     = tag_reg;
    assign lo_out  = lo_in | ((MY_IDX == lo_idx) ? val_reg : '0);
    assign hi_out  = hi_in | ((MY_IDX == hi_idx) ? val_reg : '0);

    // delete closes the gap from above, insert opens one from below
    always_comb
    begin
        val_next = val_reg;
        tag_next = tag_reg;
        priority if (cmd.del && del_out)
        begin
            val_next = next_val;
            tag_next = next_tag;
        end
        else if (cmd.ins && prev_gt)
        begin
            val_next = prev_val;
            tag_next = prev_tag;
        end
        else if (cmd.ins && gt)
        begin
            val_next = cmd.new_val;
            tag_next = new_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

[hdl/beacon_offset_median_sync_core.sv]
// top level: sequencer, sorted cell chain, median, staleness check and apb register
//
// channel  | role   | moves
// item     | sink   | op, local_time_us, master_time_us
// result   | source | clock_offset, master_estimate, sync_valid, sample_count
// apb      | slave  | stale_limit_ms at byte address 0
//
// a query or clear goes from idle to the staleness check and the result
// a beacon steps the chain: delete oldest if full, insert sorted, pick, mean, round
// one item is in work at a time; the next is taken while the result register waits
// rst_n clears the sequencer, count, ring slot, offset, last beacon; presets register
// a stalled result holds the sequencer in its last step until the register is free
`default_nettype none

module beacon_offset_median_sync_core import bmos_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bmos_item_if.sink             item,
    bmos_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "beacon_offset_median_sync_core_defines.svh"

    localparam int TAG_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(WINDOW_DEPTH);
    localparam logic [TAG_W-1:0] LAST_SLOT = TAG_W'(WINDOW_DEPTH - 1);

    seq_state_t state_reg;
    seq_state_t state_next;

    cell_cmd_t  cmd;
    logic       accept;
    logic       load_res;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [TAG_W-1:0]   slot_reg;
    logic [TAG_W-1:0]   slot_next;
    stamp_t             median_reg;
    stamp_t             median_next;
    stamp_t             last_reg;
    stamp_t             last_next;
    logic [STALE_W-1:0] stale_reg;
    logic [STALE_W-1:0] stale_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    stamp_t             local_reg;
    stamp_t             local_next;
    stamp_t             new_val_reg;
    stamp_t             new_val_next;
    stamp_t             lo_reg;
    stamp_t             lo_next;
    stamp_t             hi_reg;
    stamp_t             hi_next;
    stamp_t             fl_reg;
    stamp_t             fl_next;
    logic               x0_reg;
    logic               x0_next;
    stamp_t             elapsed_reg;
    stamp_t             elapsed_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    stamp_t             out_offset_reg;
    stamp_t             out_offset_next;
    stamp_t             out_master_reg;
    stamp_t             out_master_next;
    logic               out_sync_reg;
    logic               out_sync_next;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [COUNT_OUT_W-1:0] out_count_next;

    logic [CNT_W-1:0]   hi_idx;
    logic [CNT_W-1:0]   lo_idx;
    stamp_t             mix;

    stamp_t             val_w [WINDOW_DEPTH+2];
    logic [TAG_W-1:0]   tag_w [WINDOW_DEPTH+2];
    logic               gt_w  [WINDOW_DEPTH+1];
    logic               del_w [WINDOW_DEPTH+1];
    stamp_t             lo_w  [WINDOW_DEPTH+1];
    stamp_t             hi_w  [WINDOW_DEPTH+1];

    logic               reg_idx;
    logic               cfg_write;
    logic               del_hit;
    logic               top_free;

    // apb register
    assign reg_idx   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && (reg_idx == REG_STALE_LIMIT);
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_STALE_LIMIT) ? APB_DATA_W'(stale_reg) : '0;

    // cell chain
    assign val_w[0]              = '0;
    assign val_w[WINDOW_DEPTH+1] = '0;
    assign tag_w[0]              = '0;
    assign tag_w[WINDOW_DEPTH+1] = '0;
    assign gt_w[0]               = 1'b0;
    assign del_w[0]              = 1'b0;
    assign lo_w[0]               = '0;
    assign hi_w[0]               = '0;

    assign hi_idx = count_reg >> 1;
    assign lo_idx = count_reg[0] ? hi_idx : hi_idx - 1'b1;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        bmos_cell #(
            .DEPTH (WINDOW_DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .new_tag  (slot_reg),
            .del_tag  (slot_reg),
            .count    (count_reg),
            .lo_idx   (lo_idx),
            .hi_idx   (hi_idx),
            .prev_val (val_w[i]),
            .prev_tag (tag_w[i]),
            .prev_gt  (gt_w[i]),
            .next_val (val_w[i+2]),
            .next_tag (tag_w[i+2]),
            .del_in   (del_w[i]),
            .lo_in    (lo_w[i]),
            .hi_in    (hi_w[i]),
            .val      (val_w[i+1]),
            .tag      (tag_w[i+1]),
            .gt       (gt_w[i+1]),
            .del_out  (del_w[i+1]),
            .lo_out   (lo_w[i+1]),
            .hi_out   (hi_w[i+1])
        );
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.op == OP_BEACON)
                        state_next = (count_reg == FULL) ? S_DEL : S_INS;
                    else
                        state_next = S_STALE;
                end
            end
            S_DEL:   state_next = S_INS;
            S_INS:   state_next = S_PICK;
            S_PICK:  state_next = S_MEAN;
            S_MEAN:  state_next = S_FIX;
            S_FIX:   state_next = S_STALE;
            S_STALE: state_next = S_RES;
            S_RES:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item.ready  = (state_reg == S_IDLE);
        accept      = (state_reg == S_IDLE) && item.valid;
        load_res    = (state_reg == S_RES) && (!out_valid_reg || result.ready);
        cmd.del     = (state_reg == S_DEL);
        cmd.ins     = (state_reg == S_INS);
        cmd.new_val = new_val_reg;
    end

    assign mix = lo_reg ^ hi_reg;

    // datapath
    always_comb
    begin
        count_next      = count_reg;
        slot_next       = slot_reg;
        median_next     = median_reg;
        last_next       = last_reg;
        stale_next      = cfg_write ? pwdata[STALE_W-1:0] : stale_reg;
        local_next      = local_reg;
        new_val_next    = new_val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        fl_next         = fl_reg;
        x0_next         = x0_reg;
        elapsed_next    = elapsed_reg;
        limit_next      = limit_reg;
        out_offset_next = out_offset_reg;
        out_master_next = out_master_reg;
        out_sync_next   = out_sync_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg;

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    local_next = item.local_time_us;
                    if (item.op == OP_BEACON)
                    begin
                        new_val_next = item.master_time_us - item.local_time_us;
                        last_next    = item.local_time_us;
                    end
                    else if (item.op == OP_CLEAR)
                    begin
                        count_next  = '0;
                        slot_next   = '0;
                        median_next = '0;
                        last_next   = '0;
                    end
                end
            end
            S_DEL:
            begin
                count_next = count_reg - 1'b1;
            end
            S_INS:
            begin
                count_next = count_reg + 1'b1;
                slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
            end
            S_PICK:
            begin
                lo_next = lo_w[WINDOW_DEPTH];
                hi_next = hi_w[WINDOW_DEPTH];
            end
            S_MEAN:
            begin
                // floor of the mean, then toward zero when negative and odd
                fl_next = (lo_reg & hi_reg) + {mix[TIME_W-1], mix[TIME_W-1:1]};
                x0_next = mix[0];
            end
            S_FIX:
            begin
                median_next = fl_reg + TIME_W'(fl_reg[TIME_W-1] & x0_reg);
            end
            S_STALE:
            begin
                elapsed_next = local_reg - last_reg;
                limit_next   = LIMIT_W'(stale_reg) * LIMIT_W'(US_PER_MS);
            end
            S_RES:
            begin
                if (load_res)
                begin
                    out_offset_next = median_reg;
                    out_master_next = local_reg + median_reg;
                    out_sync_next   = (count_reg != '0) &&
                                      (elapsed_reg < TIME_W'(limit_reg));
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    out_valid_next  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            slot_reg      <= '0;
            median_reg    <= '0;
            last_reg      <= '0;
            stale_reg     <= STALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            median_reg    <= median_next;
            last_reg      <= last_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        local_reg      <= local_next;
        new_val_reg    <= new_val_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        fl_reg         <= fl_next;
        x0_reg         <= x0_next;
        elapsed_reg    <= elapsed_next;
        limit_reg      <= limit_next;
        out_offset_reg <= out_offset_next;
        out_master_reg <= out_master_next;
        out_sync_reg   <= out_sync_next;
        out_count_reg  <= out_count_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.clock_offset    = $signed(out_offset_reg);
    assign result.master_estimate = out_master_reg;
    assign result.sync_valid      = out_sync_reg;
    assign result.sample_count    = out_count_reg;

    assign del_hit  = (count_reg == FULL) && del_w[WINDOW_DEPTH];
    assign top_free = gt_w[WINDOW_DEPTH];

    `BMOS_ASSERT_HOLDS(a_count_range, count_reg <= FULL, "count beyond depth")
    `BMOS_ASSERT_IMPLIES(a_del_found, state_reg == S_DEL, del_hit, "no oldest entry on delete")
    `BMOS_ASSERT_IMPLIES(a_ins_room, state_reg == S_INS, top_free, "top cell live on insert")
    `BMOS_ASSERT_NEXT(a_ins_count, state_reg == S_INS, count_reg != '0, "empty after insert")
    `BMOS_ASSERT_NEXT(a_single_item, accept, !item.ready, "item taken while busy")

endmodule

`default_nettype wire

[tb/tb_beacon_offset_median_sync_core.sv]
// testbench for the beacon offset median sync core
module tb_beacon_offset_median_sync_core import bmos_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES = 4;
    localparam int PHASE_ITEMS = 175;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_STALE_LIMIT = APB_ADDR_W'(REG_STALE_LIMIT) << 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam stamp_t MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam stamp_t MIN_NEG = 64'h8000_0000_0000_0000;
    localparam stamp_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [APB_DATA_W-1:0] PHASE_STALE [PHASES] =
        '{32'd1000000, 32'd0, 32'hFFF0_07D0, 32'hFFFF_FFFF};
    localparam int PHASE_SEND_IDLE [PHASES] = '{32, 60, 0, 0};
    localparam int PHASE_RECV_STALL [PHASES] = '{60, 32, 0, 0};

    typedef struct {
        logic [OP_W-1:0] op;
        stamp_t          local_time_us;
        stamp_t          master_time_us;
    } beacon_item_t;

    typedef struct {
        logic signed [TIME_W-1:0] clock_offset;
        stamp_t                   master_estimate;
        logic                     sync_valid;
        logic [COUNT_OUT_W-1:0]   sample_count;
    } sync_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bmos_item_if   item_bus ();
    bmos_result_if result_bus ();

    beacon_offset_median_sync_core #(
        .WINDOW_DEPTH(WINDOW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_bus),
        .result(result_bus),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    beacon_item_t item_backlog [$];
    sync_report_t predicted_sync [$];
    beacon_item_t next_item;
    sync_report_t want;

    logic signed [TIME_W-1:0] ring_offsets [WINDOW];
    int                       ring_fill = 0;
    int                       ring_slot = 0;
    logic signed [TIME_W-1:0] median_now = '0;
    stamp_t                   last_beacon_time = '0;
    logic [STALE_W-1:0]       stale_ms = STALE_RESET;

    stamp_t gen_now = '0;
    stamp_t gen_last = '0;
    stamp_t base_off = '0;

    int   send_idle_pct = 32;
    int   recv_stall_pct = 60;
    int   fail_count = 0;
    logic item_fired = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_bus.valid = 1'b0;
        item_bus.op = OP_QUERY;
        item_bus.local_time_us = '0;
        item_bus.master_time_us = '0;
        result_bus.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic signed [TIME_W-1:0] window_median();
        logic signed [TIME_W-1:0] sorted [WINDOW];
        logic signed [TIME_W-1:0] v;
        logic signed [TIME_W:0]   pair_sum;
        int                       j;
        for (int i = 0; i < ring_fill; i++)
            sorted[i] = ring_offsets[i];
        for (int i = 1; i < ring_fill; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (ring_fill % 2 == 1)
            return sorted[ring_fill/2];
        pair_sum = {sorted[ring_fill/2-1][TIME_W-1], sorted[ring_fill/2-1]} +
                   {sorted[ring_fill/2][TIME_W-1], sorted[ring_fill/2]};
        // halve toward zero
        if (pair_sum[TIME_W] && pair_sum[0])
            pair_sum = pair_sum + 1;
        return pair_sum[TIME_W:1];
    endfunction

    task automatic track_offset(input beacon_item_t it);
        sync_report_t rep;
        stamp_t       lim;
        case (it.op)
            OP_BEACON:
            begin
                ring_offsets[ring_slot] = it.master_time_us - it.local_time_us;
                ring_slot = (ring_slot + 1) % WINDOW;
                if (ring_fill < WINDOW)
                    ring_fill++;
                median_now = window_median();
                last_beacon_time = it.local_time_us;
            end
            OP_CLEAR:
            begin
                ring_fill = 0;
                ring_slot = 0;
                median_now = '0;
                last_beacon_time = '0;
            end
            default:
            begin
            end
        endcase
        lim = TIME_W'(stale_ms) * TIME_W'(US_PER_MS);
        rep.clock_offset = median_now;
        rep.master_estimate = it.local_time_us + stamp_t'(median_now);
        rep.sync_valid = (ring_fill != 0) && ((it.local_time_us - last_beacon_time) < lim);
        rep.sample_count = COUNT_OUT_W'(ring_fill);
        predicted_sync.push_back(rep);
    endtask

    // item driver and result ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_bus.valid || item_fired)
            begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = item_backlog.pop_front();
                    item_bus.valid <= 1'b1;
                    item_bus.op <= next_item.op;
                    item_bus.local_time_us <= next_item.local_time_us;
                    item_bus.master_time_us <= next_item.master_time_us;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on item acceptance, check on result acceptance
    always @(posedge clk)
    begin
        item_fired <= item_bus.valid && item_bus.ready;
        if (rst_n && item_bus.valid && item_bus.ready)
            track_offset('{item_bus.op, item_bus.local_time_us, item_bus.master_time_us});
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (predicted_sync.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count++;
            end
            else
            begin
                want = predicted_sync.pop_front();
                if (result_bus.clock_offset !== want.clock_offset)
                begin
                    $error("clock_offset: expected %0d, got %0d", want.clock_offset,
                           result_bus.clock_offset);
                    fail_count++;
                end
                if (result_bus.master_estimate !== want.master_estimate)
                begin
                    $error("master_estimate: expected %0h, got %0h", want.master_estimate,
                           result_bus.master_estimate);
                    fail_count++;
                end
                if (result_bus.sync_valid !== want.sync_valid)
                begin
                    $error("sync_valid: expected %0b, got %0b", want.sync_valid,
                           result_bus.sync_valid);
                    fail_count++;
                end
                if (result_bus.sample_count !== want.sample_count)
                begin
                    $error("sample_count: expected %0d, got %0d", want.sample_count,
                           result_bus.sample_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
                || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL beacon_offset_median_sync_core");
        $finish;
    end

    function automatic stamp_t rand_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic stamp_t offset_base();
        case ($urandom_range(3))
            0: return stamp_t'($urandom_range(4000)) - stamp_t'(2000);
            1: return MAX_POS - stamp_t'($urandom_range(2000));
            2: return MIN_NEG + stamp_t'($urandom_range(2000));
            default: return rand_stamp();
        endcase
    endfunction

    // gap after the last beacon, weighted toward the stale boundary
    function automatic stamp_t stale_probe_gap();
        stamp_t lim;
        lim = TIME_W'(stale_ms) * TIME_W'(US_PER_MS);
        case ($urandom_range(9))
            0: return '0;
            1: return lim - 1;
            2: return lim;
            3: return lim + 1;
            8: return rand_stamp();
            9: return stamp_t'($urandom_range(3000));
            default: return stamp_t'($urandom_range(32'(2 * lim)));
        endcase
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input stamp_t local_t,
                              input stamp_t master_t);
        beacon_item_t it;
        it.op = op;
        it.local_time_us = local_t;
        it.master_time_us = master_t;
        item_backlog.push_back(it);
    endtask

    task automatic wait_for_drain();
        while (item_backlog.size() != 0 || item_bus.valid || predicted_sync.size() != 0)
            @(negedge clk);
    endtask

    // write the stale limit register (or an unmapped one), then read the stale limit back
    task automatic set_stale_limit(input logic [APB_ADDR_W-1:0] addr,
                                   input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_STALE_LIMIT)
            stale_ms = data[STALE_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_STALE_LIMIT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(stale_ms))
        begin
            $error("stale_limit_ms readback: expected %0d, got %0d", stale_ms, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items, input int pause_at);
        int                r;
        logic [OP_W-1:0]   op;
        stamp_t            t;
        stamp_t            jitter;
        base_off = offset_base();
        for (int i = 0; i < n_items; i++)
        begin
            if (i == pause_at)
                wait_for_drain();
            r = $urandom_range(99);
            if (r < 4)
            begin
                gen_now = gen_now + stamp_t'($urandom_range(1, 5000));
                queue_item(OP_CLEAR, gen_now, rand_stamp());
                gen_last = '0;
            end
            else if (r < 12)
            begin
                op = OP_W'($urandom_range(3));
                t = rand_stamp();
                queue_item(op, t, rand_stamp());
                if (op == OP_BEACON)
                    gen_last = t;
                else if (op == OP_CLEAR)
                    gen_last = '0;
                gen_now = t;
            end
            else if (r < 55)
            begin
                if ($urandom_range(49) == 0)
                    base_off = offset_base();
                gen_now = gen_now + stamp_t'($urandom_range(3000));
                if ($urandom_range(9) == 0)
                    jitter = rand_stamp();
                else
                    jitter = stamp_t'($urandom_range(1000)) - stamp_t'(500);
                queue_item(OP_BEACON, gen_now, gen_now + base_off + jitter);
                gen_last = gen_now;
            end
            else
            begin
                gen_now = gen_last + stale_probe_gap();
                queue_item(($urandom_range(9) == 0) ? OP_SPARE : OP_QUERY, gen_now,
                           rand_stamp());
            end
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);

        queue_item(OP_QUERY, 0, ALL_ONES);
        queue_item(OP_SPARE, ALL_ONES, 0);
        queue_item(OP_BEACON, 1000, 1005);
        queue_item(OP_QUERY, 1000 + 2000000 - 1, 0);
        queue_item(OP_QUERY, 1000 + 2000000, 0);
        queue_item(OP_CLEAR, 77, ALL_ONES);
        queue_item(OP_BEACON, 0, MAX_POS);
        queue_item(OP_BEACON, ALL_ONES, MAX_POS - 1);
        queue_item(OP_CLEAR, ALL_ONES, 0);
        queue_item(OP_BEACON, 0, MIN_NEG);
        queue_item(OP_BEACON, 5, MIN_NEG + 5);
        queue_item(OP_BEACON, 10, 9);
        queue_item(OP_CLEAR, 0, 0);
        queue_item(OP_BEACON, 0, ALL_ONES);
        queue_item(OP_BEACON, 1, 1);
        queue_item(OP_BEACON, 2, 0);
        queue_item(OP_BEACON, 3, 0);
        // fill past the window depth near the top of the local clock
        for (int i = 0; i < 5; i++)
            queue_item(OP_BEACON, ALL_ONES - 40 + stamp_t'(8 * i),
                       ALL_ONES - 40 + stamp_t'(15 * i));
        queue_item(OP_QUERY, 3, 0);
        queue_item(OP_SPARE, ALL_ONES, ALL_ONES);
        wait_for_drain();

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            set_stale_limit(ADDR_STALE_LIMIT, PHASE_STALE[p]);
            if (p >= 2)
                set_stale_limit(ADDR_UNMAPPED, $urandom);
            run_random_phase(PHASE_ITEMS, (p == 0) ? 80 : -1);
            wait_for_drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS beacon_offset_median_sync_core");
        else
            $display("FAIL beacon_offset_median_sync_core");
        $finish;
    end

endmodule
